/* rtl/softmax_regression_sgd_trainer_top_assert.svh */
// assertion macros for the softmax regression trainer
// used inside modules that have clk and arst_n in scope
`ifndef SOFTMAX_REGRESSION_SGD_TRAINER_TOP_ASSERT_SVH
`define SOFTMAX_REGRESSION_SGD_TRAINER_TOP_ASSERT_SVH

// same-cycle implication
`define SRT_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/srt_pkg.sv */
// shared types and constants of the softmax regression trainer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_FEATURE = 2'd1,
		OP_READ    = 2'd2,
		OP_FLUSH   = 2'd3
	} opcode_t;

	localparam logic [1:0] REG_NUM_FEATURES  = 2'd0;
	localparam logic [1:0] REG_NUM_CLASSES   = 2'd1;
	localparam logic [1:0] REG_BATCH_SIZE    = 2'd2;
	localparam logic [1:0] REG_LEARNING_RATE = 2'd3;

	localparam int ONE_Q16    = 65536;
	localparam int LOG2E_Q16  = 94548;
	localparam int LN2_Q16    = 45426;
	localparam int EXP_CUTOFF = 32 * 65536;
	localparam int EXP_TERMS  = 5;
	localparam int DIV_NW     = 48;

	typedef enum logic [5:0] {
		S_CLEAR, S_IDLE, S_LOAD, S_READ, S_READ_WAIT,
		S_FEAT, S_FEAT_BASE, S_MAC_RD, S_MAC_MUL, S_MAC_ACC,
		S_MAX, S_EXP_D, S_EXP_U, S_EXP_Y, S_EXP_P, S_EXP_Q, S_EXP_I, S_EXP_FIN,
		S_PROB, S_ERR, S_GR_RD, S_GR_MUL, S_GR_WR, S_SAMPLE_END,
		S_UPD_INIT, S_UPD_LIM, S_UPD_RD, S_UPD_LO, S_UPD_HI, S_UPD_DIV, S_UPD_WR,
		S_DIV, S_RESULT
	} state_t;

endpackage

`default_nettype wire

/* rtl/srt_ram.sv */
// generic simple dual-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module srt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/softmax_regression_sgd_trainer_top.sv */
// softmax regression trainer, minibatch sgd in q16.16, one shared multiplier and divider
// depends on srt_pkg, srt_ram and softmax_regression_sgd_trainer_top_assert.svh
// a feature does one shared multiply per class; the last feature of a sample adds per class
// an exp of five divides (none when it underflows) and a probability divide, plus
// num_features gradient steps; an update walks the gradient store and divides only its
// nonzero entries (48-bit radix-2 restoring divider); one item at a time; ready only when
// idle; reset clears control, then a clearing pass over all MAX_FEATURES*MAX_CLASSES
// entries zeroes the gradient store before the first transfer
`timescale 1ns / 1ps
`default_nettype none
`include "softmax_regression_sgd_trainer_top_assert.svh"

module softmax_regression_sgd_trainer_top #(
	parameter int MAX_FEATURES = 1024,
	parameter int MAX_CLASSES  = 16,
	parameter int MAX_BATCH    = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// weight_index[13:0], weight_value[45:14], feature_value[77:46], label[81:78]
	input  logic [srt_pkg::IN_TDATA_W-1:0]      s_tdata,
	// opcode[1:0]
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// read_value[31:0]
	output logic [srt_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// sample_done[0], batch_updated[1]
	output logic [1:0]                          m_tuser,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_addr,
	input  logic [15:0]                         cfg_wdata
);

	import srt_pkg::*;

	localparam int WDEPTH = MAX_FEATURES * MAX_CLASSES;
	localparam int WAW = $clog2(WDEPTH);
	localparam int WCW = $clog2(WDEPTH + 1);
	localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int NFW = $clog2(MAX_FEATURES + 1);
	localparam int NCW = $clog2(MAX_CLASSES + 1);
	localparam int CIW = $clog2(MAX_CLASSES);
	localparam int BSW = $clog2(MAX_BATCH + 1);

	// configuration
	logic [10:0] nf_reg_q;
	logic [4:0]  nc_reg_q;
	logic [8:0]  bs_reg_q;
	logic [15:0] lr_q;
	logic [NFW-1:0] nf_c;
	logic [NCW-1:0] nc_c;
	logic [BSW-1:0] bs_c;

	// item
	logic [13:0] widx_q;
	logic [31:0] wval_q;
	logic [31:0] x_q;
	logic [3:0]  label_q;

	state_t state_q, state_d, ret_q;
	logic [FAW-1:0] fc_q;
	logic [BSW-1:0] bc_q;
	logic [WCW-1:0] hw_q;
	logic [CIW-1:0] c_q;
	logic signed [47:0] logit_q [MAX_CLASSES];
	logic [16:0] ex_q [MAX_CLASSES];
	logic signed [47:0] mx_q;
	logic [23:0] sum_q;
	logic [WAW-1:0] wbase_q;
	logic [5:0] n_q;
	logic signed [17:0] y_q;
	logic signed [19:0] p_q;
	logic [2:0] it_q;
	logic qneg_q;
	logic signed [17:0] err_q;
	logic [FAW-1:0] j_q;
	logic [WAW-1:0] gi_q;
	logic [WCW-1:0] nfnc_q, end_q, ui_q;
	logic gneg_q;
	logic [47:0] mag_q, lo_q;
	logic [72:0] div_q;
	logic [5:0] dcnt_q;
	logic [23:0] dd_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mp_q;

	logic [31:0] res_rd_q;
	logic res_done_q, res_upd_q;
	logic m_valid_q, m_done_q, m_upd_q;
	logic [31:0] m_rd_q;

	// memories
	logic w_we, w_re, g_we, g_re, f_we, f_re;
	logic [WAW-1:0] w_waddr, w_raddr, g_waddr, g_raddr;
	logic [FAW-1:0] f_waddr, f_raddr;
	logic [31:0] w_wdata, w_rdata, f_rdata;
	logic [47:0] g_wdata, g_rdata;

	srt_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_weight_ram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.re(w_re), .raddr(w_raddr), .rdata(w_rdata)
	);
	srt_ram #(.WIDTH(48), .DEPTH(WDEPTH)) u_grad_ram (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.re(g_re), .raddr(g_raddr), .rdata(g_rdata)
	);
	srt_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_feat_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(x_q),
		.re(f_re), .raddr(f_raddr), .rdata(f_rdata)
	);

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		logic signed [47:0] r;
		if (v[48] != v[47]) begin
			r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [49:0] v);
		logic [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -50'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// clamped configuration
	always_comb begin
		if (nf_reg_q == '0) begin
			nf_c = NFW'(1);
		end else if (32'(nf_reg_q) > MAX_FEATURES) begin
			nf_c = NFW'(MAX_FEATURES);
		end else begin
			nf_c = NFW'(nf_reg_q);
		end
		if (nc_reg_q < 5'd2) begin
			nc_c = NCW'(2);
		end else if (32'(nc_reg_q) > MAX_CLASSES) begin
			nc_c = NCW'(MAX_CLASSES);
		end else begin
			nc_c = NCW'(nc_reg_q);
		end
		if (bs_reg_q == '0) begin
			bs_c = BSW'(1);
		end else if (32'(bs_reg_q) > MAX_BATCH) begin
			bs_c = BSW'(MAX_BATCH);
		end else begin
			bs_c = BSW'(bs_reg_q);
		end
	end

	logic accept, out_free, wr_ok, fi_last, c_last, j_last, ui_last;
	logic signed [47:0] lc;
	logic signed [48:0] d49, nd49, acc49, gsum49;
	logic exp_big;
	logic [72:0] div_t, div_nx;
	logic [47:0] quot;
	logic signed [17:0] qv, qmag;
	logic signed [19:0] p_nx;
	logic [16:0] ex_nx;
	logic [23:0] sum_d;
	logic signed [17:0] err_nx;
	logic signed [47:0] g_s;
	logic [47:0] gmag;
	logic [63:0] total;
	logic signed [49:0] stepv, wnew;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign wr_ok    = 32'(widx_q) < WDEPTH;
	assign fi_last  = (NFW'(fc_q) + NFW'(1)) >= nf_c;
	assign c_last   = (NCW'(c_q) + NCW'(1)) == nc_c;
	assign j_last   = (j_q == fc_q);
	assign ui_last  = (ui_q + WCW'(1)) == end_q;

	assign lc      = logit_q[c_q];
	assign d49     = {lc[47], lc} - {mx_q[47], mx_q};
	assign nd49    = -d49;
	assign exp_big = nd49 > 49'sd2097152;
	assign acc49   = {lc[47], lc} + {mp_q[63], mp_q[63:16]};
	assign gsum49  = {g_rdata[47], g_rdata} + {mp_q[63], mp_q[63:16]};

	// restoring divider step
	assign div_t  = {div_q[71:0], 1'b0};
	assign div_nx = (div_t[72:48] >= {1'b0, dd_q}) ?
		{div_t[72:48] - {1'b0, dd_q}, div_t[47:1], 1'b1} : div_t;
	assign quot   = div_q[47:0];

	assign qv    = mp_q[33:16];
	assign qmag  = qv[17] ? -qv : qv;
	assign p_nx  = 20'sd65536 + (qneg_q ? -$signed({2'b00, quot[17:0]})
		: $signed({2'b00, quot[17:0]}));
	assign ex_nx = (p_q[19] || n_q >= 6'd32) ? 17'd0 : 17'(p_q[16:0] >> n_q[4:0]);
	assign sum_d = (sum_q == '0) ? 24'd1 : sum_q;
	assign err_nx = $signed({1'b0, quot[16:0]}) -
		((32'(c_q) == 32'(label_q)) ? 18'sd65536 : 18'sd0);

	assign g_s   = g_rdata;
	assign gmag  = g_s[47] ? 48'(-g_s) : 48'(g_s);
	assign total = {16'd0, lo_q} + {mp_q[31:0], 32'd0};
	assign stepv = gneg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
	assign wnew  = 50'($signed(w_rdata)) - stepv;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (ui_q == WCW'(WDEPTH - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					case (opcode_t'(s_tuser))
						OP_LOAD:    state_d = S_LOAD;
						OP_READ:    state_d = S_READ;
						OP_FEATURE: state_d = S_FEAT;
						default:    state_d = (bc_q != '0) ? S_UPD_INIT : S_RESULT;
					endcase
				end
			end
			S_LOAD:      state_d = S_RESULT;
			S_READ:      state_d = S_READ_WAIT;
			S_READ_WAIT: state_d = S_RESULT;
			S_FEAT:      state_d = S_FEAT_BASE;
			S_FEAT_BASE: state_d = S_MAC_RD;
			S_MAC_RD:    state_d = S_MAC_MUL;
			S_MAC_MUL:   state_d = S_MAC_ACC;
			S_MAC_ACC: begin
				if (!c_last) state_d = S_MAC_RD;
				else state_d = fi_last ? S_MAX : S_RESULT;
			end
			S_MAX:   if (c_last) state_d = S_EXP_D;
			S_EXP_D: begin
				if (!exp_big) state_d = S_EXP_U;
				else if (c_last) state_d = S_PROB;
			end
			S_EXP_U:   state_d = S_EXP_Y;
			S_EXP_Y:   state_d = S_EXP_P;
			S_EXP_P:   state_d = S_EXP_Q;
			S_EXP_Q:   state_d = S_DIV;
			S_EXP_I:   state_d = (it_q == 3'd1) ? S_EXP_FIN : S_EXP_P;
			S_EXP_FIN: state_d = c_last ? S_PROB : S_EXP_D;
			S_PROB:    state_d = S_DIV;
			S_ERR:     state_d = S_GR_RD;
			S_GR_RD:   state_d = S_GR_MUL;
			S_GR_MUL:  state_d = S_GR_WR;
			S_GR_WR: begin
				if (!j_last) state_d = S_GR_RD;
				else state_d = c_last ? S_SAMPLE_END : S_PROB;
			end
			S_SAMPLE_END: state_d = ((bc_q + BSW'(1)) >= bs_c) ? S_UPD_INIT : S_RESULT;
			S_UPD_INIT: state_d = S_UPD_LIM;
			S_UPD_LIM:  state_d = S_UPD_RD;
			S_UPD_RD:   state_d = S_UPD_LO;
			S_UPD_LO:   state_d = (g_rdata == '0) ? S_UPD_WR : S_UPD_HI;
			S_UPD_HI:   state_d = S_UPD_DIV;
			S_UPD_DIV:  state_d = S_DIV;
			S_UPD_WR:   state_d = ui_last ? S_RESULT : S_UPD_RD;
			S_DIV:      if (dcnt_q == 6'(DIV_NW - 1)) state_d = ret_q;
			S_RESULT:   if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory controls and multiplier operands
	always_comb begin
		w_we = 1'b0; w_re = 1'b0; w_waddr = WAW'(widx_q); w_raddr = WAW'(widx_q);
		w_wdata = wval_q;
		g_we = 1'b0; g_re = 1'b0; g_waddr = ui_q[WAW-1:0]; g_raddr = ui_q[WAW-1:0];
		g_wdata = '0;
		f_we = 1'b0; f_re = 1'b0; f_waddr = fc_q; f_raddr = j_q;
		mul_a = '0; mul_b = '0;
		case (state_q)
			S_CLEAR: g_we = 1'b1;
			S_LOAD:  w_we = wr_ok;
			S_READ:  w_re = 1'b1;
			S_FEAT: begin
				f_we  = 1'b1;
				mul_a = 33'(fc_q);
				mul_b = 33'(nc_c);
			end
			S_MAC_RD: begin
				w_re    = 1'b1;
				w_raddr = wbase_q + WAW'(c_q);
			end
			S_MAC_MUL: begin
				mul_a = 33'($signed(x_q));
				mul_b = 33'($signed(w_rdata));
			end
			S_EXP_D: begin
				mul_a = 33'(nd49[21:0]);
				mul_b = 33'(LOG2E_Q16);
			end
			S_EXP_U: begin
				mul_a = 33'(mp_q[31:16]);
				mul_b = 33'(LN2_Q16);
			end
			S_EXP_P: begin
				mul_a = 33'(y_q);
				mul_b = 33'(p_q);
			end
			S_GR_RD: begin
				f_re    = 1'b1;
				g_re    = 1'b1;
				g_raddr = gi_q;
			end
			S_GR_MUL: begin
				mul_a = 33'($signed(f_rdata));
				mul_b = 33'(err_q);
			end
			S_GR_WR: begin
				g_we    = 1'b1;
				g_waddr = gi_q;
				g_wdata = sat48(gsum49);
			end
			S_UPD_INIT: begin
				mul_a = 33'(nf_c);
				mul_b = 33'(nc_c);
			end
			S_UPD_RD: begin
				g_re    = 1'b1;
				w_re    = 1'b1;
				w_raddr = ui_q[WAW-1:0];
			end
			S_UPD_LO: begin
				mul_a = 33'(gmag[31:0]);
				mul_b = 33'(lr_q);
			end
			S_UPD_HI: begin
				mul_a = 33'(mag_q[47:32]);
				mul_b = 33'(lr_q);
			end
			S_UPD_WR: begin
				g_we    = 1'b1;
				w_we    = ui_q < nfnc_q;
				w_waddr = ui_q[WAW-1:0];
				w_wdata = sat32(wnew);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mp_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			widx_q  <= s_tdata[13:0];
			wval_q  <= s_tdata[45:14];
			x_q     <= s_tdata[77:46];
			label_q <= s_tdata[81:78];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_reg_q <= 11'd1;
			nc_reg_q <= 5'd10;
			bs_reg_q <= 9'd100;
			lr_q     <= 16'd6554;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_NUM_FEATURES:  nf_reg_q <= cfg_wdata[10:0];
				REG_NUM_CLASSES:   nc_reg_q <= cfg_wdata[4:0];
				REG_BATCH_SIZE:    bs_reg_q <= cfg_wdata[8:0];
				REG_LEARNING_RATE: lr_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ret_q      <= S_IDLE;
			fc_q       <= '0;
			bc_q       <= '0;
			hw_q       <= '0;
			c_q        <= '0;
			ui_q       <= '0;
			res_rd_q   <= '0;
			res_done_q <= 1'b0;
			res_upd_q  <= 1'b0;
			dcnt_q     <= '0;
			for (int k = 0; k < MAX_CLASSES; k++) begin
				logit_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: ui_q <= ui_q + WCW'(1);
				S_IDLE: begin
					if (accept) begin
						res_rd_q   <= '0;
						res_done_q <= 1'b0;
						res_upd_q  <= 1'b0;
						if (opcode_t'(s_tuser) == OP_FLUSH) begin
							fc_q <= '0;
							for (int k = 0; k < MAX_CLASSES; k++) begin
								logit_q[k] <= '0;
							end
						end
					end
				end
				S_READ_WAIT: res_rd_q <= wr_ok ? w_rdata : 32'd0;
				S_FEAT_BASE: begin
					wbase_q <= mp_q[WAW-1:0];
					c_q     <= '0;
				end
				S_MAC_ACC: begin
					logit_q[c_q] <= sat48(acc49);
					if (!c_last) begin
						c_q <= c_q + CIW'(1);
					end else if (fi_last) begin
						mx_q <= logit_q[0];
						c_q  <= CIW'(1);
					end else begin
						fc_q <= fc_q + FAW'(1);
					end
				end
				S_MAX: begin
					if (lc > mx_q) mx_q <= lc;
					if (c_last) begin
						c_q   <= '0;
						sum_q <= '0;
					end else begin
						c_q <= c_q + CIW'(1);
					end
				end
				S_EXP_D: begin
					if (exp_big) begin
						ex_q[c_q] <= '0;
						c_q <= c_last ? '0 : c_q + CIW'(1);
					end
				end
				S_EXP_U: n_q <= mp_q[37:32];
				S_EXP_Y: begin
					y_q  <= -$signed({2'b00, mp_q[31:16]});
					p_q  <= 20'sd65536;
					it_q <= 3'(EXP_TERMS);
				end
				S_EXP_Q: begin
					qneg_q <= qv[17];
					div_q  <= 73'(qmag);
					dd_q   <= 24'(it_q);
					dcnt_q <= '0;
					ret_q  <= S_EXP_I;
				end
				S_EXP_I: begin
					p_q  <= p_nx;
					it_q <= it_q - 3'd1;
				end
				S_EXP_FIN: begin
					ex_q[c_q] <= ex_nx;
					sum_q     <= sum_q + 24'(ex_nx);
					c_q       <= c_last ? '0 : c_q + CIW'(1);
				end
				S_PROB: begin
					div_q  <= 73'({ex_q[c_q], 16'd0});
					dd_q   <= sum_d;
					dcnt_q <= '0;
					ret_q  <= S_ERR;
				end
				S_ERR: begin
					err_q <= err_nx;
					j_q   <= '0;
					gi_q  <= WAW'(c_q);
				end
				S_GR_WR: begin
					if ((WCW'(gi_q) + WCW'(1)) > hw_q) hw_q <= WCW'(gi_q) + WCW'(1);
					if (!j_last) begin
						j_q  <= j_q + FAW'(1);
						gi_q <= gi_q + WAW'(nc_c);
					end else if (!c_last) begin
						c_q <= c_q + CIW'(1);
					end
				end
				S_SAMPLE_END: begin
					fc_q       <= '0;
					res_done_q <= 1'b1;
					bc_q       <= bc_q + BSW'(1);
					for (int k = 0; k < MAX_CLASSES; k++) begin
						logit_q[k] <= '0;
					end
				end
				S_UPD_LIM: begin
					nfnc_q <= mp_q[WCW-1:0];
					end_q  <= (hw_q > mp_q[WCW-1:0]) ? hw_q : mp_q[WCW-1:0];
					ui_q   <= '0;
				end
				S_UPD_LO: begin
					gneg_q <= g_s[47];
					mag_q  <= gmag;
					if (g_rdata == '0) div_q <= '0;
				end
				S_UPD_HI: lo_q <= mp_q[47:0];
				S_UPD_DIV: begin
					div_q  <= 73'(total[63:16]);
					dd_q   <= 24'(bs_c);
					dcnt_q <= '0;
					ret_q  <= S_UPD_WR;
				end
				S_UPD_WR: begin
					if (ui_last) begin
						hw_q      <= '0;
						bc_q      <= '0;
						res_upd_q <= 1'b1;
					end else begin
						ui_q <= ui_q + WCW'(1);
					end
				end
				S_DIV: begin
					div_q  <= div_nx;
					dcnt_q <= dcnt_q + 6'd1;
				end
				default: ;
			endcase
		end
	end

	// output register, frees the input side while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_rd_q    <= '0;
			m_done_q  <= 1'b0;
			m_upd_q   <= 1'b0;
		end else begin
			if (state_q == S_RESULT && out_free) begin
				m_valid_q <= 1'b1;
				m_rd_q    <= res_rd_q;
				m_done_q  <= res_done_q;
				m_upd_q   <= res_upd_q;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_rd_q;
	assign m_tuser  = {m_upd_q, m_done_q};

	`SRT_ASSERT_IMPL(a_ready_only_idle, s_tready, state_q == S_IDLE, "ready outside idle")
	`SRT_ASSERT_NEXT(a_busy_after_transfer, s_tvalid && s_tready, !s_tready, "ready after transfer")
	`SRT_ASSERT_IMPL(a_div_nonzero, state_q == S_DIV, dd_q != '0, "divide by zero")
	`SRT_ASSERT_NEXT(a_result_loaded, state_q == S_RESULT && out_free, m_tvalid, "result lost")

endmodule

`default_nettype wire
